// ===== hw/rtl/ste_pkg.sv =====
// shared types and constants for the sorted table engine
`timescale 1ns / 1ps
package ste_pkg;

  // item kinds
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_SEARCH  = 3'd1;
  localparam logic [2:0] KIND_GET     = 3'd2;
  localparam logic [2:0] KIND_RM_POS  = 3'd3;
  localparam logic [2:0] KIND_RM_VAL  = 3'd4;
  localparam logic [2:0] KIND_CLEAR   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  // search modes
  localparam logic [1:0] MODE_FIRST   = 2'd1;
  localparam logic [1:0] MODE_LAST    = 2'd2;

  // register indexes
  localparam logic REG_SEARCH_MODE = 1'b0;
  localparam logic REG_UNIQUE_ONLY = 1'b1;

  // fixed field widths
  localparam int KEY_BITS   = 32;
  localparam int POS_BITS   = 8;
  localparam int IDX_BITS   = 9;
  localparam int PADDR_BITS = 3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_PROBE_RD,
    S_PROBE_CMP,
    S_LOC_DONE,
    S_ADD_DECIDE,
    S_UP_CHECK,
    S_UP_WR,
    S_DN_CHECK,
    S_DN_WR,
    S_SCAN_CHECK,
    S_SCAN_CMP,
    S_GET_WAIT,
    S_OUT
  } ste_state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT_EMPTY,
    CMD_INIT_ADD,
    CMD_INIT_SEARCH,
    CMD_READ_MID,
    CMD_STEP,
    CMD_UP_INIT,
    CMD_READ_PTRM1,
    CMD_WRITE_UP,
    CMD_WRITE_KEY,
    CMD_SET_PTR_POS,
    CMD_READ_PTR,
    CMD_WRITE_DN,
    CMD_REMOVE_DONE,
    CMD_SCAN_INIT,
    CMD_SCAN_HIT,
    CMD_PTR_INC,
    CMD_CLEAR,
    CMD_READ_POS,
    CMD_RES_NOTFOUND,
    CMD_RES_RANGE,
    CMD_RES_BADKIND,
    CMD_RES_SEARCH,
    CMD_RES_DUP,
    CMD_RES_FULL,
    CMD_RES_GET
  } ste_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] kind;
    logic       count_zero;
    logic       pos_ok;
    logic       dup;
    logic       full;
    logic       step_done;
    logic       up_done;
    logic       ptr_end;
    logic       key_eq;
  } ste_stat_t;

endpackage

// ===== hw/rtl/ste_if.sv =====
// valid/ready channel interfaces for table requests and results
`timescale 1ns / 1ps
interface ste_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] key;
  logic [7:0]  position;

  modport source (output valid, kind, key, position, input ready);
  modport sink (input valid, kind, key, position, output ready);
endinterface

interface ste_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [8:0]  index;
  logic [31:0] value;
  logic [8:0]  count;

  modport source (output valid, status, index, value, count, input ready);
  modport sink (input valid, status, index, value, count, output ready);
endinterface

// ===== hw/rtl/ste_ctrl.sv =====
// sequencer for search, shift and scan steps of the table
`timescale 1ns / 1ps
module ste_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ste_pkg::ste_stat_t stat,
  output ste_pkg::ste_cmd_t  cmd
);
  import ste_pkg::*;

  ste_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.kind)
          KIND_ADD: state_next = stat.count_zero ? S_ADD_DECIDE : S_PROBE_RD;
          KIND_SEARCH: state_next = stat.count_zero ? S_OUT : S_PROBE_RD;
          KIND_GET: state_next = stat.pos_ok ? S_GET_WAIT : S_OUT;
          KIND_RM_POS: state_next = stat.pos_ok ? S_DN_CHECK : S_OUT;
          KIND_RM_VAL: state_next = S_SCAN_CHECK;
          default: state_next = S_OUT;
        endcase
      end
      S_PROBE_RD: state_next = S_PROBE_CMP;
      S_PROBE_CMP: state_next = stat.step_done ? S_LOC_DONE : S_PROBE_RD;
      S_LOC_DONE: state_next = (stat.kind == KIND_ADD) ? S_ADD_DECIDE : S_OUT;
      S_ADD_DECIDE: state_next = (stat.dup || stat.full) ? S_OUT : S_UP_CHECK;
      S_UP_CHECK: state_next = stat.up_done ? S_OUT : S_UP_WR;
      S_UP_WR: state_next = S_UP_CHECK;
      S_DN_CHECK: state_next = stat.ptr_end ? S_OUT : S_DN_WR;
      S_DN_WR: state_next = S_DN_CHECK;
      S_SCAN_CHECK: state_next = stat.ptr_end ? S_OUT : S_SCAN_CMP;
      S_SCAN_CMP: state_next = stat.key_eq ? S_DN_CHECK : S_SCAN_CHECK;
      S_GET_WAIT: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands and handshake
  always_comb begin
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_DISPATCH: begin
        case (stat.kind)
          KIND_ADD: cmd = stat.count_zero ? CMD_INIT_EMPTY : CMD_INIT_ADD;
          KIND_SEARCH: cmd = stat.count_zero ? CMD_RES_NOTFOUND : CMD_INIT_SEARCH;
          KIND_GET: cmd = stat.pos_ok ? CMD_READ_POS : CMD_RES_RANGE;
          KIND_RM_POS: cmd = stat.pos_ok ? CMD_SET_PTR_POS : CMD_RES_RANGE;
          KIND_RM_VAL: cmd = CMD_SCAN_INIT;
          KIND_CLEAR: cmd = CMD_CLEAR;
          default: cmd = CMD_RES_BADKIND;
        endcase
      end
      S_PROBE_RD: cmd = CMD_READ_MID;
      S_PROBE_CMP: cmd = CMD_STEP;
      S_LOC_DONE: begin
        if (stat.kind != KIND_ADD) cmd = CMD_RES_SEARCH;
      end
      S_ADD_DECIDE: begin
        if (stat.dup) cmd = CMD_RES_DUP;
        else if (stat.full) cmd = CMD_RES_FULL;
        else cmd = CMD_UP_INIT;
      end
      S_UP_CHECK: cmd = stat.up_done ? CMD_WRITE_KEY : CMD_READ_PTRM1;
      S_UP_WR: cmd = CMD_WRITE_UP;
      S_DN_CHECK: cmd = stat.ptr_end ? CMD_REMOVE_DONE : CMD_READ_PTR;
      S_DN_WR: cmd = CMD_WRITE_DN;
      S_SCAN_CHECK: cmd = stat.ptr_end ? CMD_RES_NOTFOUND : CMD_READ_PTR;
      S_SCAN_CMP: cmd = stat.key_eq ? CMD_SCAN_HIT : CMD_PTR_INC;
      S_GET_WAIT: cmd = CMD_RES_GET;
      S_OUT: out_valid = 1'b1;
      default: cmd = CMD_NONE;
    endcase
  end

  // a beat is taken only from idle, a result only leaves from the output state
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("ready and result valid at once");
  a_load_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted beat not dispatched");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ===== hw/rtl/ste_dp.sv =====
// table memory, search bounds, shift pointer, history and result registers
`timescale 1ns / 1ps
module ste_dp #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ste_pkg::ste_cmd_t               cmd,
  output ste_pkg::ste_stat_t              stat,
  input  logic [2:0]                      in_kind,
  input  logic [ste_pkg::KEY_BITS-1:0]    in_key,
  input  logic [ste_pkg::POS_BITS-1:0]    in_position,
  input  logic [1:0]                      search_mode,
  input  logic                            unique_only,
  output logic [2:0]                      res_status,
  output logic [ste_pkg::IDX_BITS-1:0]    res_index,
  output logic [ste_pkg::KEY_BITS-1:0]    res_value,
  output logic [ste_pkg::IDX_BITS-1:0]    res_count
);
  import ste_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata;
  logic [IW-1:0]        raddr, waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic                 we;

  logic [2:0]           item_kind;
  logic [KEY_WIDTH-1:0] item_key;
  logic [POS_BITS-1:0]  item_pos;

  logic [CW-1:0] lo, hi, mid, ptr, count;
  logic          hit;
  logic [IW-1:0] last_ins, prior_ins;
  logic [1:0]    run;

  logic          key_eq, key_lt, mode_any, stay;
  logic [CW-1:0] lo_n, hi_n, mid_n, add_probe;
  logic [CW:0]   mid_sum;
  logic          turn;

  // compare of the probed entry against the item key
  assign key_eq   = (item_key == rdata);
  assign key_lt   = (item_key < rdata);
  assign mode_any = (search_mode != MODE_FIRST) && (search_mode != MODE_LAST);
  assign stay     = key_eq && mode_any;

  // next search bounds
  always_comb begin
    lo_n = lo;
    hi_n = hi;
    if (key_eq) begin
      if (search_mode == MODE_FIRST) hi_n = mid;
      else if (search_mode == MODE_LAST) lo_n = mid + CW'(1);
    end else if (key_lt) begin
      hi_n = mid;
    end else begin
      lo_n = mid + CW'(1);
    end
  end

  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n   = mid_sum[CW:1];

  // first probe of an add follows a run of inserts in one direction
  assign add_probe = (run[1] && (CW'(last_ins) < count)) ? CW'(last_ins) : (count >> 1);
  assign turn      = (prior_ins < last_ins) != (last_ins < IW'(mid));

  // status to the sequencer
  always_comb begin
    stat.kind       = item_kind;
    stat.count_zero = (count == '0);
    stat.pos_ok     = PW'(item_pos) < PW'(count);
    stat.dup        = hit && unique_only;
    stat.full       = (count == CW'(CAPACITY));
    stat.step_done  = stay || (lo_n == hi_n);
    stat.up_done    = (ptr == mid);
    stat.ptr_end    = (ptr >= count);
    stat.key_eq     = key_eq;
  end

  // memory port addressing
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (cmd)
      CMD_READ_MID:   raddr = IW'(mid);
      CMD_READ_POS:   raddr = IW'(item_pos);
      CMD_READ_PTR:   raddr = IW'(ptr);
      CMD_READ_PTRM1: raddr = IW'(ptr - CW'(1));
      CMD_WRITE_UP: begin
        we    = 1'b1;
        waddr = IW'(ptr);
      end
      CMD_WRITE_DN: begin
        we    = 1'b1;
        waddr = IW'(ptr - CW'(1));
      end
      CMD_WRITE_KEY: begin
        we    = 1'b1;
        waddr = IW'(mid);
        wdata = item_key;
      end
      default: raddr = '0;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // item capture, pointers and results
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_ins  <= '0;
      prior_ins <= '0;
      run       <= '0;
      lo        <= '0;
      hi        <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          item_kind <= in_kind;
          item_key  <= KEY_WIDTH'(in_key);
          item_pos  <= in_position;
        end
        CMD_INIT_EMPTY: begin
          lo  <= '0;
          hi  <= '0;
          mid <= '0;
          hit <= 1'b0;
        end
        CMD_INIT_ADD: begin
          lo  <= '0;
          hi  <= count;
          mid <= add_probe;
          hit <= 1'b0;
        end
        CMD_INIT_SEARCH: begin
          lo  <= '0;
          hi  <= count;
          mid <= count >> 1;
          hit <= 1'b0;
        end
        CMD_STEP: begin
          if (key_eq) hit <= 1'b1;
          if (!stay) begin
            lo  <= lo_n;
            hi  <= hi_n;
            mid <= mid_n;
          end
        end
        CMD_UP_INIT: begin
          ptr       <= count;
          prior_ins <= last_ins;
          last_ins  <= IW'(mid);
          if (turn) run <= '0;
          else if (!run[1]) run <= run + 2'd1;
        end
        CMD_WRITE_UP: ptr <= ptr - CW'(1);
        CMD_WRITE_KEY: begin
          count      <= count + CW'(1);
          res_status <= ST_OK;
          res_index  <= IDX_BITS'(mid);
          res_value  <= '0;
        end
        CMD_SET_PTR_POS: begin
          mid <= CW'(item_pos);
          ptr <= CW'(item_pos) + CW'(1);
        end
        CMD_WRITE_DN: ptr <= ptr + CW'(1);
        CMD_REMOVE_DONE: begin
          count      <= count - CW'(1);
          last_ins   <= '0;
          prior_ins  <= '0;
          run        <= '0;
          res_status <= ST_OK;
          res_index  <= IDX_BITS'(mid);
          res_value  <= '0;
        end
        CMD_SCAN_INIT: ptr <= '0;
        CMD_SCAN_HIT: begin
          mid <= ptr;
          ptr <= ptr + CW'(1);
        end
        CMD_PTR_INC: ptr <= ptr + CW'(1);
        CMD_CLEAR: begin
          count      <= '0;
          last_ins   <= '0;
          prior_ins  <= '0;
          run        <= '0;
          res_status <= ST_OK;
          res_index  <= '0;
          res_value  <= '0;
        end
        CMD_RES_NOTFOUND: begin
          res_status <= ST_NOT_FOUND;
          res_index  <= '0;
          res_value  <= '0;
        end
        CMD_RES_RANGE: begin
          res_status <= ST_RANGE;
          res_index  <= IDX_BITS'(item_pos);
          res_value  <= '0;
        end
        CMD_RES_BADKIND: begin
          res_status <= ST_RANGE;
          res_index  <= '0;
          res_value  <= '0;
        end
        CMD_RES_SEARCH: begin
          res_status <= hit ? ST_OK : ST_NOT_FOUND;
          res_index  <= IDX_BITS'(mid);
          res_value  <= '0;
        end
        CMD_RES_DUP: begin
          res_status <= ST_DUP;
          res_index  <= IDX_BITS'(mid);
          res_value  <= '0;
        end
        CMD_RES_FULL: begin
          res_status <= ST_FULL;
          res_index  <= IDX_BITS'(mid);
          res_value  <= '0;
        end
        CMD_RES_GET: begin
          res_status <= ST_OK;
          res_index  <= IDX_BITS'(item_pos);
          res_value  <= KEY_BITS'(rdata);
        end
        default: ;
      endcase
    end
  end

  assign res_count = IDX_BITS'(count);

  // fill level and bound checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_WRITE_KEY) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the table");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_REMOVE_DONE) |=> (count == $past(count) - CW'(1)))
    else $error("removal did not shrink the table");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    lo <= hi)
    else $error("search bounds crossed");

endmodule

// ===== hw/rtl/sorted_table_engine.sv =====
// sorted key table: request/result channels, config registers, sequencer and datapath
//
//   channel | dir | beat contents
//   req     | in  | kind, key, position
//   rsp     | out | status, index, value, count
//   apb     | in  | search_mode at 0x0, unique_only at 0x4
//
// one item at a time; each search probe is a memory read, then a compare, and an item
// also passes through dispatch, wrap-up, output and idle.
// inserts and removals move the following entries through the memory, a read then
// a write per entry; remove by value scans entries, each a read then a compare.
// reset clears the count and insert history; the entry memory is not cleared.
// req is ready only while idle; a result holds on rsp until taken.
`timescale 1ns / 1ps
module sorted_table_engine #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  ste_req_if.sink                          req,
  ste_rsp_if.source                        rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ste_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ste_pkg::*;

  logic [1:0] search_mode;
  logic       unique_only;
  ste_cmd_t   cmd;
  ste_stat_t  stat;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= '0;
      unique_only <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SEARCH_MODE: search_mode <= pwdata[1:0];
        REG_UNIQUE_ONLY: unique_only <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_SEARCH_MODE: prdata = {30'd0, search_mode};
      REG_UNIQUE_ONLY: prdata = {31'd0, unique_only};
      default: prdata = '0;
    endcase
  end

  ste_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ste_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (req.kind),
    .in_key      (req.key),
    .in_position (req.position),
    .search_mode (search_mode),
    .unique_only (unique_only),
    .res_status  (rsp.status),
    .res_index   (rsp.index),
    .res_value   (rsp.value),
    .res_count   (rsp.count)
  );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the sorted table engine
`timescale 1ns / 1ps
module tb;
  import ste_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [7:0]  position;
  } table_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [8:0]  index;
    logic [31:0] value;
    logic [8:0]  count;
  } table_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ste_req_if req ();
  ste_rsp_if rsp ();

  sorted_table_engine dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow of the table and its settings
  logic [31:0] shadow_keys [256];
  int          shadow_count;
  int          last_ins;
  int          prior_ins;
  int          run_len;
  logic [1:0]  cur_mode;
  logic        cur_unique;

  table_op_t   pending_ops [$];
  table_rsp_t  expected_rsps [$];
  int          errors;
  int          accepted;
  logic        hold_rsp;

  // binary search from a given first probe
  function automatic int locate_key(logic [31:0] key, int probe, output bit hit);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_count;
    mid = probe;
    hit = 1'b0;
    do begin
      if (key == shadow_keys[mid]) begin
        hit = 1'b1;
        if (cur_mode == MODE_FIRST) hi = mid;
        else if (cur_mode == MODE_LAST) lo = mid + 1;
        else return mid;
      end else if (key < shadow_keys[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
      mid = (lo + hi) >> 1;
    end while (lo != hi);
    return mid;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i < shadow_count - 1; i++) shadow_keys[i] = shadow_keys[i + 1];
    shadow_count--;
    last_ins = 0;
    prior_ins = 0;
    run_len = 0;
  endfunction

  // apply one op to the shadow table and return the result it should give
  function automatic table_rsp_t apply_table_op(table_op_t op);
    table_rsp_t r;
    bit hit;
    int pos, probe, a, b;
    r.status = ST_OK;
    r.index = '0;
    r.value = '0;
    hit = 1'b0;
    case (op.kind)
      KIND_ADD: begin
        pos = 0;
        if (shadow_count > 0) begin
          probe = shadow_count >> 1;
          if (run_len >= 2 && last_ins < shadow_count) probe = last_ins;
          pos = locate_key(op.key, probe, hit);
        end
        r.index = pos[8:0];
        if (hit && cur_unique) begin
          r.status = ST_DUP;
        end else if (shadow_count >= 256) begin
          r.status = ST_FULL;
        end else begin
          a = prior_ins - last_ins;
          b = last_ins - pos;
          if ((a < 0) != (b < 0)) run_len = 0;
          else if (run_len < 2) run_len++;
          prior_ins = last_ins;
          last_ins = pos;
          for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[pos] = op.key;
          shadow_count++;
        end
      end
      KIND_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          pos = locate_key(op.key, shadow_count >> 1, hit);
          r.index = pos[8:0];
          r.status = hit ? ST_OK : ST_NOT_FOUND;
        end
      end
      KIND_GET: begin
        r.index = {1'b0, op.position};
        if (op.position < shadow_count) r.value = shadow_keys[op.position];
        else r.status = ST_RANGE;
      end
      KIND_RM_POS: begin
        r.index = {1'b0, op.position};
        if (op.position < shadow_count) drop_entry(op.position);
        else r.status = ST_RANGE;
      end
      KIND_RM_VAL: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] == op.key) begin
            r.index = i[8:0];
            r.status = ST_OK;
            drop_entry(i);
            break;
          end
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        last_ins = 0;
        prior_ins = 0;
        run_len = 0;
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = shadow_count[8:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  int req_gap;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req_gap = 0;
    end else if (!(req.valid && !req.ready)) begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(apply_table_op(pending_ops.pop_front()));
        accepted++;
        req_gap = pick_gap();
      end
      if (req_gap > 0) begin
        req_gap--;
        req.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        req.valid <= 1'b1;
        req.kind <= pending_ops[0].kind;
        req.key <= pending_ops[0].key;
        req.position <= pending_ops[0].position;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  int rsp_gap;
  always @(posedge clk) begin
    table_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.index !== want.index) begin
            $error("index: expected %0d actual %0d", want.index, rsp.index);
            errors++;
          end
          if (rsp.value !== want.value) begin
            $error("value: expected %h actual %h", want.value, rsp.value);
            errors++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d actual %0d", want.count, rsp.count);
            errors++;
          end
        end
      end
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
      end
    end
  end

  // long back-pressure stretch on the result side
  initial begin
    hold_rsp = 1'b0;
    while (accepted < 150) @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  task automatic reg_write(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] mode, logic uniq);
    drain();
    reg_write({REG_SEARCH_MODE, 2'b00}, {30'd0, mode});
    reg_write({REG_UNIQUE_ONLY, 2'b00}, {31'd0, uniq});
    cur_mode = mode;
    cur_unique = uniq;
  endtask

  task automatic push_op(logic [2:0] kind, logic [31:0] key, logic [7:0] position);
    table_op_t op;
    op.kind = kind;
    op.key = key;
    op.position = position;
    pending_ops.push_back(op);
  endtask

  task automatic push_random_op();
    int r;
    logic [2:0] kind;
    logic [31:0] key;
    logic [7:0] position;
    r = $urandom_range(0, 99);
    if (r < 40) kind = KIND_ADD;
    else if (r < 60) kind = KIND_SEARCH;
    else if (r < 70) kind = KIND_GET;
    else if (r < 78) kind = KIND_RM_POS;
    else if (r < 90) kind = KIND_RM_VAL;
    else if (r < 92) kind = KIND_CLEAR;
    else if (r < 94) kind = 3'($urandom_range(6, 7));
    else kind = KIND_SEARCH;
    r = $urandom_range(0, 99);
    if (r < 50) key = $urandom_range(0, 15);
    else if (r < 75) key = $urandom_range(0, 200);
    else key = $urandom;
    if ($urandom_range(0, 99) < 85) position = $urandom_range(0, 31);
    else position = $urandom_range(0, 255);
    push_op(kind, key, position);
  endtask

  // main sequence
  initial begin
    logic [1:0] modes [8] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
    logic       uniqs [8] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    errors = 0;
    accepted = 0;
    shadow_count = 0;
    last_ins = 0;
    prior_ins = 0;
    run_len = 0;
    cur_mode = 2'd0;
    cur_unique = 1'b0;
    req.valid = 1'b0;
    req.kind = '0;
    req.key = '0;
    req.position = '0;
    rsp.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, every kind
    set_mode(2'd0, 1'b0);
    push_op(KIND_SEARCH, 32'd7, 8'd0);
    push_op(KIND_GET, 32'd0, 8'd0);
    push_op(KIND_RM_POS, 32'd0, 8'd255);
    push_op(KIND_RM_VAL, 32'd7, 8'd0);
    push_op(KIND_ADD, 32'h0000_0000, 8'd0);
    push_op(KIND_ADD, 32'hFFFF_FFFF, 8'd0);
    push_op(KIND_ADD, 32'd5, 8'd0);
    push_op(KIND_ADD, 32'd5, 8'd0);
    push_op(KIND_ADD, 32'd5, 8'd0);
    push_op(KIND_SEARCH, 32'd5, 8'd0);
    push_op(KIND_SEARCH, 32'd6, 8'd0);
    push_op(KIND_GET, 32'd0, 8'd4);
    push_op(KIND_GET, 32'd0, 8'd255);
    push_op(3'd6, 32'hFFFF_FFFF, 8'hFF);
    push_op(3'd7, 32'd0, 8'd0);
    push_op(KIND_RM_VAL, 32'd5, 8'd0);
    push_op(KIND_RM_POS, 32'd0, 8'd0);
    set_mode(2'd1, 1'b1);
    push_op(KIND_SEARCH, 32'd5, 8'd0);
    push_op(KIND_ADD, 32'd5, 8'd0);
    set_mode(2'd2, 1'b0);
    push_op(KIND_SEARCH, 32'd5, 8'd0);
    push_op(KIND_CLEAR, 32'd0, 8'd0);

    // fill to capacity, then full and duplicate-before-full cases
    for (int i = 0; i < 256; i++) push_op(KIND_ADD, 32'(2 * i), 8'd0);
    push_op(KIND_ADD, 32'd1, 8'd0);
    set_mode(2'd3, 1'b1);
    push_op(KIND_ADD, 32'd2, 8'd0);
    push_op(KIND_GET, 32'd0, 8'd255);
    push_op(KIND_RM_POS, 32'd0, 8'd0);
    push_op(KIND_CLEAR, 32'd0, 8'd0);

    // random phases under varying settings
    for (int p = 0; p < 8; p++) begin
      set_mode(modes[p], uniqs[p]);
      for (int i = 0; i < 52; i++) push_random_op();
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
